// ===== rtl/ccode_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccode_pkg: shared types and constants
// Q16.16 fixed point constants, operation codes and helpers for the
// cell-cycle derivative block.
// ----------------------------------------------------------------------------
package ccode_pkg;

  localparam int W = 32;
  localparam int FB = 16;

  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  // rounded Q16.16 constants
  localparam logic signed [W-1:0] C_ONE   = 32'sd65536;
  localparam logic signed [W-1:0] C_0_02  = 32'sd1311;
  localparam logic signed [W-1:0] C_0_5   = 32'sd32768;
  localparam logic signed [W-1:0] C_0_01  = 32'sd655;
  localparam logic signed [W-1:0] C_0_8   = 32'sd52429;
  localparam logic signed [W-1:0] C_0_05  = 32'sd3277;
  localparam logic signed [W-1:0] C_0_2   = 32'sd13107;
  localparam logic signed [W-1:0] C_0_1   = 32'sd6554;
  localparam logic signed [W-1:0] C_0_001 = 32'sd66;
  localparam logic signed [W-1:0] C_0_25  = 32'sd16384;
  localparam logic signed [W-1:0] C_0_15  = 32'sd9830;
  localparam logic signed [W-1:0] C_3     = 32'sd196608;
  localparam logic signed [W-1:0] C_1_2   = 32'sd78643;
  localparam logic signed [W-1:0] C_0_3   = 32'sd19661;
  localparam logic signed [W-1:0] C_0_26  = 32'sd17039;

  localparam logic [16:0] SYN_RESET = 17'd12170;
  localparam logic [18:0] FZR_RESET = 19'd191739;

  localparam logic CFG_SYN = 1'b0;
  localparam logic CFG_FZR = 1'b1;

  // micro-op codes of the back end sequencer
  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_ADD = 2'd1,
    OP_SUB = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  // operand sources: inputs 0..8, constants 9..21, temporaries 22..47
  localparam int NIN  = 9;
  localparam int NTMP = 26;

  typedef struct packed {
    op_t        op;
    logic [5:0] a;
    logic [5:0] b;
    logic [5:0] d;
  } uop_t;

  // register file layout
  localparam logic [5:0] R_X1 = 6'd0, R_X2 = 6'd1, R_X3 = 6'd2, R_X4 = 6'd3;
  localparam logic [5:0] R_X5 = 6'd4, R_X6 = 6'd5, R_X7 = 6'd6;
  localparam logic [5:0] R_V = 6'd7, R_K4 = 6'd8;
  localparam logic [5:0] R_ONE = 6'd9, R_002 = 6'd10, R_05 = 6'd11;
  localparam logic [5:0] R_001 = 6'd12, R_08 = 6'd13, R_005 = 6'd14;
  localparam logic [5:0] R_02 = 6'd15, R_01 = 6'd16, R_0001 = 6'd17;
  localparam logic [5:0] R_025 = 6'd18, R_015 = 6'd19, R_3 = 6'd20;
  localparam logic [5:0] R_12 = 6'd21;
  // temporaries
  localparam logic [5:0] T_U3 = 6'd22, T_U4 = 6'd23, T_U7 = 6'd24;
  localparam logic [5:0] T_A = 6'd25, T_B = 6'd26, T_C = 6'd27;
  localparam logic [5:0] T_R25 = 6'd28, T_RW = 6'd29, T_R2 = 6'd30;
  localparam logic [5:0] T_T1 = 6'd31, T_T2 = 6'd32, T_P = 6'd33;
  localparam logic [5:0] T_H = 6'd34, T_KI = 6'd35, T_KA = 6'd36;
  localparam logic [5:0] T_D = 6'd37, T_E = 6'd38;
  localparam logic [5:0] T_DX0 = 6'd39, T_DX1 = 6'd40, T_DX2 = 6'd41;
  localparam logic [5:0] T_DX3 = 6'd42, T_DX4 = 6'd43, T_DX5 = 6'd44;
  localparam logic [5:0] T_DX6 = 6'd45, T_F = 6'd46, T_G = 6'd47;

  // constant table for the fixed operand sources
  function automatic logic signed [W-1:0] cval(logic [5:0] s);
    case (s)
      R_ONE:   return C_ONE;
      R_002:   return C_0_02;
      R_05:    return C_0_5;
      R_001:   return C_0_01;
      R_08:    return C_0_8;
      R_005:   return C_0_05;
      R_02:    return C_0_2;
      R_01:    return C_0_1;
      R_0001:  return C_0_001;
      R_025:   return C_0_25;
      R_015:   return C_0_15;
      R_3:     return C_3;
      R_12:    return C_1_2;
      default: return '0;
    endcase
  endfunction

  function automatic uop_t u(op_t o, logic [5:0] a, logic [5:0] b, logic [5:0] d);
    uop_t r;
    r.op = o; r.a = a; r.b = b; r.d = d;
    return r;
  endfunction

  // micro program; derivatives end in T_DX0..T_DX6 then get the 1.2 scale
  function automatic uop_t prog(logic [6:0] pc);
    uop_t r;
    r = u(OP_ADD, T_A, T_A, T_A);
    case (pc)
      7'd0:  r = u(OP_SUB, R_ONE, R_X3, T_U3);
      7'd1:  r = u(OP_SUB, R_ONE, R_X4, T_U4);
      7'd2:  r = u(OP_SUB, R_ONE, R_X7, T_U7);
      7'd3:  r = u(OP_MUL, R_002, T_U4, T_A);
      7'd4:  r = u(OP_MUL, R_05, R_X4, T_B);
      7'd5:  r = u(OP_ADD, T_A, T_B, T_R25);
      7'd6:  r = u(OP_MUL, R_001, T_U3, T_A);
      7'd7:  r = u(OP_MUL, R_08, R_X3, T_B);
      7'd8:  r = u(OP_ADD, T_A, T_B, T_RW);
      7'd9:  r = u(OP_MUL, R_005, T_U7, T_A);
      7'd10: r = u(OP_MUL, R_08, R_X7, T_B);
      7'd11: r = u(OP_ADD, T_A, T_B, T_R2);
      7'd12: r = u(OP_MUL, T_R25, R_X2, T_T1);
      7'd13: r = u(OP_MUL, T_RW, R_X1, T_T2);
      7'd14: r = u(OP_ADD, R_V, T_T1, T_A);
      7'd15: r = u(OP_SUB, T_A, T_T2, T_A);
      7'd16: r = u(OP_MUL, T_R2, R_X1, T_B);
      7'd17: r = u(OP_SUB, T_A, T_B, T_DX0);
      7'd18: r = u(OP_SUB, T_T2, T_T1, T_A);
      7'd19: r = u(OP_MUL, T_R2, R_X2, T_B);
      7'd20: r = u(OP_SUB, T_A, T_B, T_DX1);
      // dx3
      7'd21: r = u(OP_MUL, R_02, T_U3, T_A);
      7'd22: r = u(OP_ADD, R_01, T_U3, T_B);
      7'd23: r = u(OP_DIV, T_A, T_B, T_C);
      7'd24: r = u(OP_MUL, R_05, R_X1, T_D);
      7'd25: r = u(OP_MUL, T_D, R_X3, T_A);
      7'd26: r = u(OP_ADD, R_01, R_X3, T_B);
      7'd27: r = u(OP_DIV, T_A, T_B, T_E);
      7'd28: r = u(OP_SUB, T_C, T_E, T_DX2);
      // dx4 (T_D still holds 0.5*x1)
      7'd29: r = u(OP_MUL, T_D, T_U4, T_A);
      7'd30: r = u(OP_ADD, R_01, T_U4, T_B);
      7'd31: r = u(OP_DIV, T_A, T_B, T_C);
      7'd32: r = u(OP_MUL, R_02, R_X4, T_A);
      7'd33: r = u(OP_ADD, R_01, R_X4, T_B);
      7'd34: r = u(OP_DIV, T_A, T_B, T_E);
      7'd35: r = u(OP_SUB, T_C, T_E, T_DX3);
      // hill term
      7'd36: r = u(OP_MUL, R_X1, R_X1, T_P);
      7'd37: r = u(OP_MUL, T_P, T_P, T_P);
      7'd38: r = u(OP_MUL, R_05, T_P, T_A);
      7'd39: r = u(OP_ADD, R_0001, T_A, T_A);
      7'd40: r = u(OP_ADD, R_ONE, T_P, T_B);
      7'd41: r = u(OP_DIV, T_A, T_B, T_H);
      7'd42: r = u(OP_MUL, R_025, R_X6, T_A);
      7'd43: r = u(OP_ADD, R_005, R_X6, T_B);
      7'd44: r = u(OP_DIV, T_A, T_B, T_KI);
      7'd45: r = u(OP_MUL, T_D, R_X5, T_A);
      7'd46: r = u(OP_ADD, R_01, R_X5, T_B);
      7'd47: r = u(OP_DIV, T_A, T_B, T_KA);
      7'd48: r = u(OP_ADD, T_H, T_KI, T_A);
      7'd49: r = u(OP_SUB, T_A, T_KA, T_A);
      7'd50: r = u(OP_MUL, R_05, R_X5, T_B);
      7'd51: r = u(OP_SUB, T_A, T_B, T_DX4);
      7'd52: r = u(OP_MUL, R_015, R_X6, T_B);
      7'd53: r = u(OP_SUB, T_KA, T_B, T_A);
      7'd54: r = u(OP_SUB, T_A, T_KI, T_DX5);
      // dx7
      7'd55: r = u(OP_MUL, R_3, R_X6, T_A);
      7'd56: r = u(OP_ADD, R_01, T_A, T_A);
      7'd57: r = u(OP_MUL, T_A, T_U7, T_A);
      7'd58: r = u(OP_ADD, R_001, T_U7, T_B);
      7'd59: r = u(OP_DIV, T_A, T_B, T_C);
      7'd60: r = u(OP_MUL, R_K4, R_X1, T_A);
      7'd61: r = u(OP_ADD, R_01, T_A, T_A);
      7'd62: r = u(OP_MUL, T_A, R_X7, T_A);
      7'd63: r = u(OP_ADD, R_005, R_X7, T_B);
      7'd64: r = u(OP_DIV, T_A, T_B, T_E);
      7'd65: r = u(OP_SUB, T_C, T_E, T_DX6);
      // scale by 1.2
      7'd66: r = u(OP_MUL, R_12, T_DX0, T_DX0);
      7'd67: r = u(OP_MUL, R_12, T_DX1, T_DX1);
      7'd68: r = u(OP_MUL, R_12, T_DX2, T_DX2);
      7'd69: r = u(OP_MUL, R_12, T_DX3, T_DX3);
      7'd70: r = u(OP_MUL, R_12, T_DX4, T_DX4);
      7'd71: r = u(OP_MUL, R_12, T_DX5, T_DX5);
      7'd72: r = u(OP_MUL, R_12, T_DX6, T_DX6);
      default: r = u(OP_ADD, T_A, T_A, T_A);
    endcase
    return r;
  endfunction

  localparam logic [6:0] PC_LAST = 7'd72;

  function automatic logic signed [W-1:0] sat33(logic signed [W:0] v);
    if (v > $signed({1'b0, WMAX})) return WMAX;
    if (v < $signed({1'b1, WMIN})) return WMIN;
    return v[W-1:0];
  endfunction

  // saturate a signed value from sign and magnitude
  function automatic logic signed [W-1:0] from_mag(logic neg, logic [47:0] m);
    if (m >= 48'h80000000) return neg ? WMIN : WMAX;
    return neg ? -$signed(m[W-1:0]) : $signed(m[W-1:0]);
  endfunction

  typedef struct packed {
    logic [31:0]        t;
    logic signed [31:0] x1, x2, x3, x4, x5, x6, x7;
  } item_t;

  typedef struct packed {
    logic signed [31:0] dy0, dy1, dy2, dy3, dy4, dy5, dy6;
    logic               g1;
    logic               ev;
    logic [31:0]        g1t;
    logic [31:0]        stt;
  } res_t;

endpackage

// ===== rtl/ccode_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccode_fifo: short item queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ccode_fifo import ccode_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr,
  input  item_t wdata,
  output logic  full,
  input  logic  rd,
  output item_t rdata,
  output logic  empty
);
  item_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  // store item
  always_ff @(posedge clk) begin
    if (wr && !full) mem_r[wp_r] <= wdata;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr && !full) wp_r <= ~wp_r;
      if (rd && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr && !full} - {1'b0, rd && !empty};
    end
  end
endmodule

// ===== rtl/ccode_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccode_div: iterative fixed point divider
// Restoring divide of (|n| << 16) by |d|, one quotient bit per cycle,
// saturated to the word.
// ----------------------------------------------------------------------------
module ccode_div import ccode_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] n,
  input  logic signed [31:0] d,
  output logic               done,
  output logic signed [31:0] q
);
  logic [47:0] num_r, quo_r;
  logic [31:0] rem_r;
  logic [31:0] den_r;
  logic        neg_r, busy_r, done_r, zero_r, nsgn_r, nz_r;
  logic [5:0]  cnt_r;
  logic [32:0] rsh;
  logic [32:0] rdif;

  assign rsh  = {rem_r, num_r[47]};
  assign rdif = rsh - {1'b0, den_r};
  assign done = done_r;

  // result with saturation
  always_comb begin
    if (zero_r) q = nz_r ? (nsgn_r ? WMIN : WMAX) : '0;
    else        q = from_mag(neg_r, quo_r);
  end

  // iterate one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        num_r  <= {(n[31] ? 32'(-n) : 32'(n)), 16'd0};
        den_r  <= d[31] ? 32'(-d) : 32'(d);
        neg_r  <= n[31] ^ d[31];
        zero_r <= (d == 0);
        nsgn_r <= n[31];
        nz_r   <= (n != 0);
        rem_r  <= '0;
        quo_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        num_r <= {num_r[46:0], 1'b0};
        if (rsh >= {1'b0, den_r}) begin
          rem_r <= rdif[31:0];
          quo_r <= {quo_r[46:0], 1'b1};
        end else begin
          rem_r <= rsh[31:0];
          quo_r <= {quo_r[46:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd47) begin
          busy_r <= 1'b0; done_r <= 1'b1;
        end
      end
    end
  end
endmodule

// ===== rtl/ccode_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccode_back: derivative sequencer
// Runs the micro program over input registers, a constant table and a
// scratch register file with a shared multiplier, adder and divider, then
// resolves the event latch.
// ----------------------------------------------------------------------------
module ccode_back import ccode_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  item_t       in_item,
  output logic        in_take,
  input  logic [16:0] syn,
  input  logic [18:0] fzr,
  output logic        res_valid,
  output res_t        res,
  input  logic        res_take
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_MULW = 5'b00100,
    S_DIVW = 5'b01000,
    S_DONE = 5'b10000
  } st_t;

  st_t                st_r, st_nxt;
  logic signed [31:0] xr_r [NIN];
  logic signed [31:0] scr_r [NTMP];
  logic [6:0]         pc_r;
  logic [31:0]        t_r;
  logic               latch_r;
  logic [31:0]        g1t_r, stt_r;
  logic               rv_r;
  res_t               res_r;
  logic [63:0]        prod_r;
  logic               pneg_r;
  uop_t               uo;
  logic [4:0]         dix;
  logic signed [31:0] opa, opb;
  logic               dstart, ddone;
  logic signed [31:0] dq;
  logic [31:0]        ma, mb;
  logic signed [31:0] mres;
  logic               g1, stopc;

  assign uo  = prog(pc_r);
  assign dix = 5'(uo.d - T_U3);
  assign ma  = opa[31] ? 32'(-opa) : 32'(opa);
  assign mb  = opb[31] ? 32'(-opb) : 32'(opb);

  // fetch operands from scratch, item registers or the constant table
  always_comb begin
    if (uo.a >= T_U3)      opa = scr_r[5'(uo.a - T_U3)];
    else if (uo.a <= R_K4) opa = xr_r[4'(uo.a)];
    else                   opa = cval(uo.a);
  end

  always_comb begin
    if (uo.b >= T_U3)      opb = scr_r[5'(uo.b - T_U3)];
    else if (uo.b <= R_K4) opb = xr_r[4'(uo.b)];
    else                   opb = cval(uo.b);
  end

  ccode_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .n(opa), .d(opb), .done(ddone), .q(dq)
  );

  assign dstart  = (st_r == S_EXEC) && (uo.op == OP_DIV);
  assign in_take = (st_r == S_IDLE) && in_valid;

  // product truncated to 16 fraction bits, saturated
  always_comb begin
    if (prod_r[63:48] != 0) mres = pneg_r ? WMIN : WMAX;
    else                    mres = from_mag(pneg_r, prod_r[63:16]);
  end

  assign g1 = (scr_r[5'(T_DX1 - T_U3)] > 0) && (xr_r[4'(R_X7)] < C_0_3) &&
              (scr_r[5'(T_DX2 - T_U3)] < 0);
  assign stopc = (xr_r[4'(R_X1)] < C_0_26) && (scr_r[5'(T_DX0 - T_U3)] < 0) &&
                 (xr_r[4'(R_X7)] > C_0_8);

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (in_valid) st_nxt = S_EXEC;
      S_EXEC: begin
        case (uo.op)
          OP_MUL:  st_nxt = S_MULW;
          OP_DIV:  st_nxt = S_DIVW;
          default: if (pc_r == PC_LAST) st_nxt = S_DONE;
        endcase
      end
      S_MULW: st_nxt = (pc_r == PC_LAST) ? S_DONE : S_EXEC;
      S_DIVW: if (ddone) st_nxt = S_EXEC;
      S_DONE: if (!rv_r || res_take) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // sequencer and register file
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          xr_r[4'(R_X1)] <= in_item.x1; xr_r[4'(R_X2)] <= in_item.x2;
          xr_r[4'(R_X3)] <= in_item.x3; xr_r[4'(R_X4)] <= in_item.x4;
          xr_r[4'(R_X5)] <= in_item.x5; xr_r[4'(R_X6)] <= in_item.x6;
          xr_r[4'(R_X7)] <= in_item.x7;
          xr_r[4'(R_V)]  <= 32'(syn);   xr_r[4'(R_K4)] <= 32'(fzr);
          t_r  <= in_item.t;
          pc_r <= '0;
        end
      end
      S_EXEC: begin
        case (uo.op)
          OP_MUL: begin
            prod_r <= ma * mb;
            pneg_r <= opa[31] ^ opb[31];
          end
          OP_ADD: begin
            scr_r[dix] <= sat33(33'(opa) + 33'(opb));
            pc_r <= pc_r + 7'd1;
          end
          OP_SUB: begin
            scr_r[dix] <= sat33(33'(opa) - 33'(opb));
            pc_r <= pc_r + 7'd1;
          end
          default: ;
        endcase
      end
      S_MULW: begin
        scr_r[dix] <= mres;
        pc_r <= pc_r + 7'd1;
      end
      S_DIVW: begin
        if (ddone) begin
          scr_r[dix] <= dq;
          pc_r <= pc_r + 7'd1;
        end
      end
      default: ;
    endcase
  end

  // resolve latch and load the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; latch_r <= 1'b0; g1t_r <= '1; stt_r <= '1; rv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DONE && (!rv_r || res_take)) begin
        logic l, e;
        logic [31:0] gt, sttn;
        l = latch_r; gt = g1t_r; sttn = stt_r; e = 1'b0;
        if (g1) begin
          if (!l) gt = t_r;
          l = 1'b1;
        end
        if (l && stopc) begin
          l = 1'b0; sttn = t_r; e = 1'b1;
        end
        latch_r <= l; g1t_r <= gt; stt_r <= sttn;
        res_r.dy0 <= scr_r[5'(T_DX0 - T_U3)]; res_r.dy1 <= scr_r[5'(T_DX1 - T_U3)];
        res_r.dy2 <= scr_r[5'(T_DX2 - T_U3)]; res_r.dy3 <= scr_r[5'(T_DX3 - T_U3)];
        res_r.dy4 <= scr_r[5'(T_DX4 - T_U3)]; res_r.dy5 <= scr_r[5'(T_DX5 - T_U3)];
        res_r.dy6 <= scr_r[5'(T_DX6 - T_U3)];
        res_r.g1 <= g1; res_r.ev <= e; res_r.g1t <= gt; res_r.stt <= sttn;
        rv_r <= 1'b1;
      end else if (res_take) begin
        rv_r <= 1'b0;
      end
    end
  end

  assign res_valid = rv_r;
  assign res = res_r;

  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> st_r == S_IDLE) else $error("item taken while busy");
  a_ev_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rv_r) && res_r.ev |-> !latch_r) else $error("latch kept after stop");
endmodule

// ===== rtl/cell_cycle_ode_derivative_event.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_cycle_ode_derivative_event: derivative evaluator with G1/stop latch
// Front queue feeds a micro-programmed back end; result held in a register.
// ----------------------------------------------------------------------------
// Sequence: an accepted item is taken from the queue, then runs 73 micro-ops
// (31 add/sub, 33 multiplies and 9 divides on one shared bit-serial divider),
// and then its result is loaded into the result register.
// The back end takes a new item only once the last one is through, and an
// unpopped result stalls the back end.
// Reset: synchronous active-low rst_n clears queue, latch, recorded times
// (to all ones) and the configuration registers to their defaults.
module cell_cycle_ode_derivative_event import ccode_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [18:0]        cfg_data,
  input  logic               push,
  output logic               full,
  input  logic [31:0]        in_sim_time,
  input  logic signed [31:0] in_cdk_active,
  input  logic signed [31:0] in_cdk_inactive,
  input  logic signed [31:0] in_wee1_level,
  input  logic signed [31:0] in_cdc25_level,
  input  logic signed [31:0] in_cdc20_inactive,
  input  logic signed [31:0] in_cdc20_active,
  input  logic signed [31:0] in_fzr1_level,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_d_cdk_active,
  output logic signed [31:0] out_d_cdk_inactive,
  output logic signed [31:0] out_d_wee1,
  output logic signed [31:0] out_d_cdc25,
  output logic signed [31:0] out_d_cdc20_inactive,
  output logic signed [31:0] out_d_cdc20_active,
  output logic signed [31:0] out_d_fzr1,
  output logic               out_g1_condition,
  output logic               out_stop_event,
  output logic [31:0]        out_g1_time_out,
  output logic [31:0]        out_stop_time_out
);
  logic [16:0] syn_r;
  logic [18:0] fzr_r;
  item_t       win, qout;
  logic        qempty, qtake, rv;
  res_t        res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      syn_r <= SYN_RESET; fzr_r <= FZR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYN: syn_r <= cfg_data[16:0];
        CFG_FZR: fzr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign win = '{t: in_sim_time, x1: in_cdk_active, x2: in_cdk_inactive,
                 x3: in_wee1_level, x4: in_cdc25_level, x5: in_cdc20_inactive,
                 x6: in_cdc20_active, x7: in_fzr1_level};

  ccode_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr(push), .wdata(win), .full(full),
    .rd(qtake), .rdata(qout), .empty(qempty)
  );

  ccode_back u_back (
    .clk(clk), .rst_n(rst_n), .in_valid(!qempty), .in_item(qout), .in_take(qtake),
    .syn(syn_r), .fzr(fzr_r), .res_valid(rv), .res(res), .res_take(pop && rv)
  );

  assign empty = !rv;
  assign out_d_cdk_active     = res.dy0;
  assign out_d_cdk_inactive   = res.dy1;
  assign out_d_wee1           = res.dy2;
  assign out_d_cdc25          = res.dy3;
  assign out_d_cdc20_inactive = res.dy4;
  assign out_d_cdc20_active   = res.dy5;
  assign out_d_fzr1           = res.dy6;
  assign out_g1_condition     = res.g1;
  assign out_stop_event       = res.ev;
  assign out_g1_time_out      = res.g1t;
  assign out_stop_time_out    = res.stt;
endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for cell_cycle_ode_derivative_event
// Drives species items through the push/full queue side, predicts the seven
// scaled derivatives and the G1/stop latch in fixed point, and checks every
// popped result field by field across several rate settings and idle mixes.
// ----------------------------------------------------------------------------
module tb;
  import ccode_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int SETTLE_CYCLES = 700;
  localparam int RAND_PER_PHASE = 175;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_SYN;
  logic [18:0] cfg_data = '0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  item_t cur = '0;
  res_t got;

  item_t pending_items[$];
  res_t expected_results[$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold = 0;
  int errors = 0;
  int cycles = 0;

  // predictor copy of configuration and latch state
  longint syn_rate = 12170;
  longint fzr_gain = 191739;
  logic g1_latch_q = 1'b0;
  logic [31:0] g1_time_q = '1;
  logic [31:0] stop_time_q = '1;

  cell_cycle_ode_derivative_event dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .in_sim_time(cur.t), .in_cdk_active(cur.x1), .in_cdk_inactive(cur.x2),
    .in_wee1_level(cur.x3), .in_cdc25_level(cur.x4), .in_cdc20_inactive(cur.x5),
    .in_cdc20_active(cur.x6), .in_fzr1_level(cur.x7),
    .empty(empty), .pop(pop),
    .out_d_cdk_active(got.dy0), .out_d_cdk_inactive(got.dy1),
    .out_d_wee1(got.dy2), .out_d_cdc25(got.dy3), .out_d_cdc20_inactive(got.dy4),
    .out_d_cdc20_active(got.dy5), .out_d_fzr1(got.dy6),
    .out_g1_condition(got.g1), .out_stop_event(got.ev),
    .out_g1_time_out(got.g1t), .out_stop_time_out(got.stt)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- arithmetic
  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint signed_of_mag(bit neg, longint unsigned m);
    if (m >= 64'h80000000) return neg ? -64'sd2147483648 : 64'sd2147483647;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint unsigned ua, ub;
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    return signed_of_mag((a < 0) != (b < 0), (ua * ub) >> FB);
  endfunction

  function automatic longint fx_div(longint n, longint d);
    longint unsigned un, ud, q, r;
    if (d == 0) return (n > 0) ? 64'sd2147483647 : (n < 0) ? -64'sd2147483648 : 0;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = un / ud;
    r = un % ud;
    for (int i = 0; i < FB && q <= 64'h80000000; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= ud) begin
        r = r - ud;
        q = q | 1;
      end
    end
    return signed_of_mag((n < 0) != (d < 0), q);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clamp_word(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return clamp_word(a - b);
  endfunction

  // derivatives, event flags and latch update for one accepted item
  function automatic res_t predict_rates(item_t it);
    longint x1, x2, x3, x4, x5, x6, x7, u3, u4, u7;
    longint r25, rw, r2, t1, t2, p, h, ki, ka, half_x1;
    longint dx[7];
    longint dy[7];
    bit g1, stopc;
    res_t r;
    x1 = it.x1; x2 = it.x2; x3 = it.x3; x4 = it.x4;
    x5 = it.x5; x6 = it.x6; x7 = it.x7;
    u3 = fx_sub(C_ONE, x3);
    u4 = fx_sub(C_ONE, x4);
    u7 = fx_sub(C_ONE, x7);
    r25 = fx_add(fx_mul(C_0_02, u4), fx_mul(C_0_5, x4));
    rw = fx_add(fx_mul(C_0_01, u3), fx_mul(C_0_8, x3));
    r2 = fx_add(fx_mul(C_0_05, u7), fx_mul(C_0_8, x7));
    t1 = fx_mul(r25, x2);
    t2 = fx_mul(rw, x1);
    dx[0] = fx_sub(fx_sub(fx_add(syn_rate, t1), t2), fx_mul(r2, x1));
    dx[1] = fx_sub(fx_sub(t2, t1), fx_mul(r2, x2));
    half_x1 = fx_mul(C_0_5, x1);
    dx[2] = fx_sub(fx_div(fx_mul(C_0_2, u3), fx_add(C_0_1, u3)),
                   fx_div(fx_mul(half_x1, x3), fx_add(C_0_1, x3)));
    dx[3] = fx_sub(fx_div(fx_mul(half_x1, u4), fx_add(C_0_1, u4)),
                   fx_div(fx_mul(C_0_2, x4), fx_add(C_0_1, x4)));
    p = fx_mul(x1, x1);
    p = fx_mul(p, p);
    h = fx_div(fx_add(C_0_001, fx_mul(C_0_5, p)), fx_add(C_ONE, p));
    ki = fx_div(fx_mul(C_0_25, x6), fx_add(C_0_05, x6));
    ka = fx_div(fx_mul(half_x1, x5), fx_add(C_0_1, x5));
    dx[4] = fx_sub(fx_sub(fx_add(h, ki), ka), fx_mul(C_0_5, x5));
    dx[5] = fx_sub(fx_sub(ka, fx_mul(C_0_15, x6)), ki);
    dx[6] = fx_sub(fx_div(fx_mul(fx_add(C_0_1, fx_mul(C_3, x6)), u7), fx_add(C_0_01, u7)),
                   fx_div(fx_mul(fx_add(C_0_1, fx_mul(fzr_gain, x1)), x7),
                          fx_add(C_0_05, x7)));
    for (int i = 0; i < 7; i++) dy[i] = fx_mul(C_1_2, dx[i]);
    // latch G1, then let the stop condition clear it
    g1 = dy[1] > 0 && x7 < C_0_3 && dy[2] < 0;
    if (g1) begin
      if (!g1_latch_q) g1_time_q = it.t;
      g1_latch_q = 1'b1;
    end
    stopc = x1 < C_0_26 && dy[0] < 0 && x7 > C_0_8;
    r.ev = 1'b0;
    if (g1_latch_q && stopc) begin
      g1_latch_q = 1'b0;
      stop_time_q = it.t;
      r.ev = 1'b1;
    end
    r.dy0 = 32'(dy[0]); r.dy1 = 32'(dy[1]); r.dy2 = 32'(dy[2]); r.dy3 = 32'(dy[3]);
    r.dy4 = 32'(dy[4]); r.dy5 = 32'(dy[5]); r.dy6 = 32'(dy[6]);
    r.g1 = g1;
    r.g1t = g1_time_q;
    r.stt = stop_time_q;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    logic nxt_push;
    item_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      nxt_push = push;
      nxt = cur;
      if (push && !full) begin
        expected_results.insert(expected_results.size(), predict_rates(cur));
        nxt_push = 1'b0;
      end
      if (!nxt_push && pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = pending_items.pop_front();
        nxt_push = 1'b1;
      end
      push <= nxt_push;
      cur <= nxt;
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_results.size() == 0) begin
          $error("result popped with no item outstanding");
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("d_cdk_active", want.dy0, got.dy0);
          check_field("d_cdk_inactive", want.dy1, got.dy1);
          check_field("d_wee1", want.dy2, got.dy2);
          check_field("d_cdc25", want.dy3, got.dy3);
          check_field("d_cdc20_inactive", want.dy4, got.dy4);
          check_field("d_cdc20_active", want.dy5, got.dy5);
          check_field("d_fzr1", want.dy6, got.dy6);
          check_field("g1_condition", 32'(want.g1), 32'(got.g1));
          check_field("stop_event", 32'(want.ev), 32'(got.ev));
          check_field("g1_time_out", want.g1t, got.g1t);
          check_field("stop_time_out", want.stt, got.stt);
        end
      end
      // hold off the receiver while a long stall is requested
      if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  logic [31:0] clock_hours = 0;

  function automatic logic [31:0] pick_level(int lo, int hi);
    case ($urandom_range(9))
      0: return $urandom;
      1: return -$urandom_range(200000);
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  // mostly biologically shaped levels, biased toward G1 or stop conditions
  function automatic item_t make_item();
    item_t it;
    int shape;
    shape = $urandom_range(9);
    clock_hours += $urandom_range(70000);
    it.t = ($urandom_range(19) == 0) ? $urandom : clock_hours;
    it.x1 = (shape < 4) ? pick_level(0, 17000) : pick_level(0, 78643);
    it.x2 = pick_level(0, 78643);
    it.x3 = pick_level(0, 78643);
    it.x4 = pick_level(0, 78643);
    it.x5 = pick_level(0, 78643);
    it.x6 = pick_level(0, 78643);
    if (shape < 4) it.x7 = pick_level(52430, 70000);
    else if (shape < 8) it.x7 = pick_level(0, 19660);
    else it.x7 = pick_level(0, 78643);
    if ($urandom_range(19) == 0) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end
    return it;
  endfunction

  task automatic queue_item(logic [31:0] t, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            logic [31:0] d, logic [31:0] e, logic [31:0] f, logic [31:0] g);
    pending_items.insert(pending_items.size(), {t, a, b, c, d, e, f, g});
  endtask

  task automatic write_reg(logic idx, logic [18:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SYN) syn_rate = val[16:0];
    else fzr_gain = val;
  endtask

  // pause the sender until every expected result has come back
  task automatic drain();
    wait (pending_items.size() == 0 && !push && expected_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) pending_items.insert(pending_items.size(), make_item());
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 26;
    rx_idle_pct = 76;

    // field extremes, zero denominators, latch sequence at reset rates
    queue_item(32'h0, 0, 0, 0, 0, 0, 0, 0);
    queue_item(32'hFFFFFFFE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    queue_item(32'h1, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h80000000, 32'h80000000, 32'h80000000);
    queue_item(32'h2, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
               32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    queue_item(32'h10000, 65536, 65536, 65536, 65536, 65536, 65536, 65536);
    queue_item(32'h20000, 0, 0, -6554, -6554, -6554, -3277, -3277);
    queue_item(32'h30000, 30000, 20000, 72090, 72090, 10000, 10000, 66191);
    queue_item(32'h40000, -30000, 40000, -6554, 72090, -6554, -3277, 66191);
    queue_item(32'h50000, 13107, 40000, 6554, 6554, 6554, 6554, 6554);
    queue_item(32'h60000, 13107, 40000, 6554, 6554, 6554, 6554, 0);
    queue_item(32'h70000, 6554, 0, 60000, 60000, 6554, 6554, 60000);
    queue_item(32'h80000, 6554, 0, 60000, 60000, 6554, 6554, 60000);
    queue_item(32'h90000, 40000, 30000, 2000, 60000, 20000, 20000, 3000);
    queue_item(32'hA0000, 1000, 0, 65536, 65536, 0, 0, 65536);
    queue_item(32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA, 32'h55555555,
               32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
    queue_item(32'h0, 32'h55555555, 32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA,
               32'h55555555, 32'hAAAAAAAA, 32'h55555555);
    drain();

    // rate extremes with sender and receiver idling
    write_reg(CFG_SYN, 19'd0);
    write_reg(CFG_FZR, 19'd0);
    run_random(RAND_PER_PHASE);
    write_reg(CFG_SYN, 19'd65536);
    write_reg(CFG_FZR, 19'd262144);
    rx_hold = 4000;
    run_random(RAND_PER_PHASE);

    // swap the idle mix
    tx_idle_pct = 76;
    rx_idle_pct = 26;
    write_reg(CFG_SYN, 19'($urandom_range(65536)));
    write_reg(CFG_FZR, 19'($urandom_range(262144)));
    run_random(RAND_PER_PHASE);
    write_reg(CFG_SYN, 19'd12170);
    write_reg(CFG_FZR, 19'd191739);
    run_random(RAND_PER_PHASE);

    // back to back
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_SYN, 19'($urandom_range(65536)));
    write_reg(CFG_FZR, 19'($urandom_range(262144)));
    run_random(RAND_PER_PHASE);
    write_reg(CFG_SYN, 19'd65536);
    write_reg(CFG_FZR, 19'd0);
    run_random(RAND_PER_PHASE);

    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
